@@ src/sswb_pkg.sv @@
// ----------------------------------------------------------------------------
// sswb_pkg
// Types and constants shared by the smoothstep window-to-byte core and its
// checker.
// ----------------------------------------------------------------------------
package sswb_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 2'd1;

    // The window ratio t is unsigned Q1.16, so 1.0 needs seventeen bits.
    localparam int T_FRAC = 16;
    localparam int T_W    = T_FRAC + 1;
    localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

    // One quotient bit is resolved in each divider stage.
    localparam int DIV_STEPS = T_FRAC;

    // Polynomial 3 - 2t in Q2.16, and its product terms.
    localparam int POLY_W = T_FRAC + 2;
    localparam logic [POLY_W-1:0] POLY_THREE = POLY_W'(3) << T_FRAC;
    localparam int SQ_W   = 2 * T_W;
    // t*t*(3-2t) never exceeds 1.0 in Q.48.
    localparam int CUBE_W = 3 * T_FRAC + 1;
    localparam int SCALED_W = CUBE_W + 8;

    localparam int PIXEL_W = 8;

    // Decode, classify, limit check, divider, t select, two products, output.
    localparam int LATENCY = 3 + DIV_STEPS + 1 + 2 + 1;

    // Outcome of the window classification, carried beside the divider data.
    typedef struct packed {
        logic forced;   // t does not come from the divider
        logic one;      // forced t is 1.0, otherwise 0
    } sswb_flags_t;

endpackage

@@ src/smoothstep_window_to_byte_core.sv @@
// ----------------------------------------------------------------------------
// smoothstep_window_to_byte_core
// Window/level transfer with a smoothstep curve: one sample in, one byte out.
// ----------------------------------------------------------------------------
// The core takes one sample on every clock and returns its display byte,
// strobed by done for a single cycle. The window ratio comes from a
// sixteen-stage restoring divider that resolves one quotient bit per stage,
// followed by two registered multiplications. Busy stays low: the
// pipeline never stalls and the receiver must take every beat as it appears.
// Window registers are written through wr_en, wr_index and wr_data, and should
// only change while no sample is in flight.
module smoothstep_window_to_byte_core
    import sswb_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic                   done,
    output logic [PIXEL_W-1:0]     pixel_byte,
    input  logic                   wr_en,
    input  logic [CFG_IDX_W-1:0]   wr_index,
    input  logic [SAMPLE_BITS-1:0] wr_data
);

    localparam int N = SAMPLE_BITS;

    logic [N-1:0] window_low_reg;
    logic [N-1:0] window_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg  <= '0;
            window_high_reg <= '1;
        end
        else if (wr_en)
        begin
            if (wr_index == REG_WINDOW_LOW)
            begin
                window_low_reg <= wr_data;
            end
            else if (wr_index == REG_WINDOW_HIGH)
            begin
                window_high_reg <= wr_data;
            end
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Valid bits for the fixed stages.
    logic v1_reg, v2_reg, vt_reg, vm1_reg, vm2_reg, done_reg;
    logic div_v_reg [0:DIV_STEPS];

    // Stage 1: signed differences.
    logic [N:0] num_reg;
    logic [N:0] den_reg;

    always_ff @(posedge clk)
    begin
        num_reg <= {1'b0, sample} - {1'b0, window_low_reg};
        den_reg <= {1'b0, window_high_reg} - {1'b0, window_low_reg};
    end

    // Stage 2: magnitudes and sign classification.
    logic [N:0]   num_mag;
    logic [N:0]   den_mag;
    logic [N-1:0] an_reg;
    logic [N-1:0] ad_reg;
    sswb_flags_t  flags2_next;
    sswb_flags_t  flags2_reg;

    always_comb
    begin
        num_mag = num_reg[N] ? (~num_reg + 1'b1) : num_reg;
        den_mag = den_reg[N] ? (~den_reg + 1'b1) : den_reg;
        flags2_next.forced = 1'b0;
        flags2_next.one    = 1'b0;
        priority if (den_reg == '0)
        begin
            // Equal edges: a hard threshold at the lower edge.
            flags2_next.forced = 1'b1;
            flags2_next.one    = !num_reg[N];
        end
        else if (num_reg == '0 || num_reg[N] != den_reg[N])
        begin
            flags2_next.forced = 1'b1;
        end
        else
        begin
            flags2_next.forced = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        an_reg     <= num_mag[N-1:0];
        ad_reg     <= den_mag[N-1:0];
        flags2_reg <= flags2_next;
    end

    // Stage 3: a ratio at or above one saturates; this loads the divider.
    logic [N-1:0]         div_r_reg     [0:DIV_STEPS];
    logic [N-1:0]         div_d_reg     [0:DIV_STEPS];
    logic [T_FRAC-1:0]    div_q_reg     [0:DIV_STEPS];
    sswb_flags_t          div_flags_reg [0:DIV_STEPS];
    sswb_flags_t          flags3_next;

    always_comb
    begin
        flags3_next = flags2_reg;
        if (!flags2_reg.forced && an_reg >= ad_reg)
        begin
            flags3_next.forced = 1'b1;
            flags3_next.one    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        div_r_reg[0]     <= an_reg;
        div_d_reg[0]     <= ad_reg;
        div_q_reg[0]     <= '0;
        div_flags_reg[0] <= flags3_next;
    end

    // Restoring divider: the partial remainder stays below the divisor, so
    // each stage needs one compare and subtract of N+1 bits.
    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_div
            logic [N:0] rem_shift;
            logic [N:0] rem_diff;
            logic       q_bit;

            always_comb
            begin
                rem_shift = {div_r_reg[k], 1'b0};
                rem_diff  = rem_shift - {1'b0, div_d_reg[k]};
                q_bit     = (rem_shift >= {1'b0, div_d_reg[k]});
            end

            always_ff @(posedge clk)
            begin
                div_r_reg[k+1]     <= q_bit ? rem_diff[N-1:0] : rem_shift[N-1:0];
                div_d_reg[k+1]     <= div_d_reg[k];
                div_q_reg[k+1]     <= {div_q_reg[k][T_FRAC-2:0], q_bit};
                div_flags_reg[k+1] <= div_flags_reg[k];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    div_v_reg[k+1] <= 1'b0;
                end
                else
                begin
                    div_v_reg[k+1] <= div_v_reg[k];
                end
            end
        end
    endgenerate

    // t select.
    logic [T_W-1:0] t_reg;
    sswb_flags_t    flags_out;

    assign flags_out = div_flags_reg[DIV_STEPS];

    always_ff @(posedge clk)
    begin
        if (flags_out.forced)
        begin
            t_reg <= flags_out.one ? T_ONE : '0;
        end
        else
        begin
            t_reg <= {1'b0, div_q_reg[DIV_STEPS]};
        end
    end

    // First product: t squared, alongside 3 - 2t.
    logic [SQ_W-1:0]   sq_reg;
    logic [POLY_W-1:0] poly_reg;

    always_ff @(posedge clk)
    begin
        sq_reg   <= SQ_W'(t_reg) * SQ_W'(t_reg);
        poly_reg <= POLY_THREE - {t_reg, 1'b0};
    end

    // Second product: t*t*(3-2t) in Q.48.
    logic [SQ_W+POLY_W-1:0] cube_full;
    logic [CUBE_W-1:0]      cube_reg;

    assign cube_full = (SQ_W+POLY_W)'(sq_reg) * (SQ_W+POLY_W)'(poly_reg);

    always_ff @(posedge clk)
    begin
        cube_reg <= cube_full[CUBE_W-1:0];
    end

    // Scale by 255 and keep the integer part.
    logic [SCALED_W-1:0] scaled;
    logic [PIXEL_W-1:0]  pixel_byte_reg;

    assign scaled = {cube_reg, 8'd0} - SCALED_W'(cube_reg);

    always_ff @(posedge clk)
    begin
        pixel_byte_reg <= scaled[3*T_FRAC +: PIXEL_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            div_v_reg[0] <= 1'b0;
            vt_reg       <= 1'b0;
            vm1_reg      <= 1'b0;
            vm2_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            v1_reg       <= accept;
            v2_reg       <= v1_reg;
            div_v_reg[0] <= v2_reg;
            vt_reg       <= div_v_reg[DIV_STEPS];
            vm1_reg      <= vt_reg;
            vm2_reg      <= vm1_reg;
            done_reg     <= vm2_reg;
        end
    end

    assign done       = done_reg;
    assign pixel_byte = pixel_byte_reg;

endmodule

@@ src/sswb_checker.sv @@
// ----------------------------------------------------------------------------
// sswb_checker
// Port-level checks on the beat timing of the smoothstep window-to-byte core.
// ----------------------------------------------------------------------------
module sswb_checker
    import sswb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // Every accepted sample yields its byte after the fixed latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted sample produced no result beat");

    // No result beat appears without a matching accepted sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result beat without an accepted sample");

    // The pipeline never pushes back on the sender.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(start) |-> !busy)
        else $error("busy raised although the pipeline cannot stall");

endmodule

bind smoothstep_window_to_byte_core sswb_checker u_sswb_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
